// ----- rtl/pmma_pkg.sv -----
package pmma_pkg;

	localparam int MASK_BITS = 16;
	localparam int CNT_SUM_W = $clog2(2 * MASK_BITS + 1);
	localparam int NODE_W = $clog2(MASK_BITS);
	localparam int VALUE_WIDTH_DEF = 16;
	localparam int SAMPLES_PER_ROUND_DEF = 8;

	typedef enum logic [1:0] {
		FUNC_OWN = 2'd0,
		FUNC_NBR = 2'd1,
		FUNC_CLR = 2'd2
	} func_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

// ----- rtl/pmma_div.sv -----
module pmma_div #(
	parameter int NUM_W = 21,
	parameter int DEN_W = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [NUM_W-1:0]        num,
	input  logic [DEN_W-1:0]        den,
	output logic [NUM_W-1:0]        quot,
	output pmma_pkg::unit_stat_t    stat
);

	localparam int CNT_W = $clog2(NUM_W);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             ge;

	// One quotient bit per cycle, most significant first.
	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign ge = shifted >= {1'b0, den_q};
	assign diff = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign quot = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- rtl/pmma_wsum.sv -----
module pmma_wsum #(
	parameter int VAL_W = 16,
	parameter int NUM_W = 21
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [pmma_pkg::MASK_BITS-1:0]    mask_a,
	input  logic [pmma_pkg::MASK_BITS-1:0]    mask_b,
	input  logic [VAL_W-1:0]                  val_a,
	input  logic [VAL_W-1:0]                  val_b,
	output logic [NUM_W-1:0]                  total,
	output logic [pmma_pkg::CNT_SUM_W-1:0]    count,
	output pmma_pkg::unit_stat_t              stat
);

	localparam int STEP_W = $clog2(pmma_pkg::MASK_BITS);

	logic [STEP_W-1:0]               step_q;
	logic                            busy_q;
	logic                            done_q;
	logic [pmma_pkg::MASK_BITS-1:0]  ma_q;
	logic [pmma_pkg::MASK_BITS-1:0]  mb_q;
	logic [VAL_W-1:0]                va_q;
	logic [VAL_W-1:0]                vb_q;
	logic [NUM_W-1:0]                total_q;
	logic [pmma_pkg::CNT_SUM_W-1:0]  count_q;
	logic [NUM_W-1:0]                add_a;
	logic [NUM_W-1:0]                add_b;

	// The masks shift out one bit per cycle; each set bit adds its record's
	// average once, so the weighted sum and the popcounts build up together.
	assign add_a = ma_q[0] ? NUM_W'(va_q) : '0;
	assign add_b = mb_q[0] ? NUM_W'(vb_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !start && (step_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(pmma_pkg::MASK_BITS - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q <= mask_a;
			mb_q <= mask_b;
			va_q <= val_a;
			vb_q <= val_b;
			total_q <= '0;
			count_q <= '0;
		end else if (busy_q) begin
			ma_q <= ma_q >> 1;
			mb_q <= mb_q >> 1;
			total_q <= total_q + add_a + add_b;
			count_q <= count_q + pmma_pkg::CNT_SUM_W'(ma_q[0])
				+ pmma_pkg::CNT_SUM_W'(mb_q[0]);
		end
	end

	assign total = total_q;
	assign count = count_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- rtl/pooled_min_max_avg_merge.sv -----
// An own sample that is not last, a clear or an unused code is taken in the idle state, which the block keeps.
// A neighbour record runs through the serial weighted sum and, if the merged mask is not
// empty, the divider; a closing own sample first has its sum divided by its sample count.
// Throughput: one item at a time, set by the bit-serial divider and the serial mask scan.
// Reset: asynchronous; clears the aggregate, the own accumulators, own_node and control.
module pooled_min_max_avg_merge #(
	parameter int SAMPLES_PER_ROUND = pmma_pkg::SAMPLES_PER_ROUND_DEF,
	parameter int VALUE_WIDTH = pmma_pkg::VALUE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pmma_pkg::NODE_W-1:0]       cfg_data,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [1:0]                        func,
	input  logic [VALUE_WIDTH-1:0]            sample_value,
	input  logic                              sample_last,
	input  logic [pmma_pkg::MASK_BITS-1:0]    neighbour_mask,
	input  logic [VALUE_WIDTH-1:0]            neighbour_min,
	input  logic [VALUE_WIDTH-1:0]            neighbour_max,
	input  logic [VALUE_WIDTH-1:0]            neighbour_avg,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic [pmma_pkg::MASK_BITS-1:0]    merged_mask,
	output logic [VALUE_WIDTH-1:0]            merged_min,
	output logic [VALUE_WIDTH-1:0]            merged_max,
	output logic [VALUE_WIDTH-1:0]            merged_avg,
	output logic                              no_participants
);

	localparam int CNT_W = $clog2(SAMPLES_PER_ROUND + 1);
	localparam int SUM_W = VALUE_WIDTH + CNT_W;
	localparam int WS_W = VALUE_WIDTH + $clog2(2 * pmma_pkg::MASK_BITS);
	localparam int NUM_W = (SUM_W > WS_W) ? SUM_W : WS_W;
	localparam int DEN_W = pmma_pkg::CNT_SUM_W;
	localparam int MB = pmma_pkg::MASK_BITS;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_OWNDIV = 5'b00010,
		S_SUM    = 5'b00100,
		S_DIV    = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t                       state_q;
	logic [pmma_pkg::NODE_W-1:0]  own_node_q;
	logic [MB-1:0]                agg_mask_q;
	logic [VALUE_WIDTH-1:0]       agg_min_q;
	logic [VALUE_WIDTH-1:0]       agg_max_q;
	logic [VALUE_WIDTH-1:0]       agg_avg_q;
	logic [VALUE_WIDTH-1:0]       own_min_q;
	logic [VALUE_WIDTH-1:0]       own_max_q;
	logic [SUM_W-1:0]             own_sum_q;
	logic [CNT_W-1:0]             own_seen_q;
	logic                         rsp_valid_q;
	logic                         ws_start_q;
	logic                         flag_q;

	logic [MB-1:0]                rec_mask_q;
	logic [VALUE_WIDTH-1:0]       rec_min_q;
	logic [VALUE_WIDTH-1:0]       rec_max_q;
	logic [VALUE_WIDTH-1:0]       rec_avg_q;
	logic [VALUE_WIDTH-1:0]       new_avg_q;
	logic [MB-1:0]                merged_mask_q;
	logic [VALUE_WIDTH-1:0]       merged_min_q;
	logic [VALUE_WIDTH-1:0]       merged_max_q;
	logic [VALUE_WIDTH-1:0]       merged_avg_q;
	logic                         no_part_q;

	logic                         accept;
	logic                         own_take;
	logic                         own_close;
	logic                         nbr_take;
	logic                         commit;
	logic [VALUE_WIDTH-1:0]       own_min_n;
	logic [VALUE_WIDTH-1:0]       own_max_n;
	logic [SUM_W-1:0]             own_sum_n;
	logic [CNT_W-1:0]             own_seen_n;
	logic                         room;
	logic [MB-1:0]                mrg_mask;
	logic [VALUE_WIDTH-1:0]       mrg_min;
	logic [VALUE_WIDTH-1:0]       mrg_max;
	logic [VALUE_WIDTH-1:0]       mrg_avg;

	logic                         div_start;
	logic [NUM_W-1:0]             div_num;
	logic [DEN_W-1:0]             div_den;
	logic [NUM_W-1:0]             div_quot;
	pmma_pkg::unit_stat_t         div_stat;
	logic [NUM_W-1:0]             ws_total;
	logic [DEN_W-1:0]             ws_count;
	pmma_pkg::unit_stat_t         ws_stat;

	assign req_ready = (state_q == S_IDLE);
	assign accept = req_valid && req_ready;
	assign own_take = accept && (pmma_pkg::func_t'(func) == pmma_pkg::FUNC_OWN);
	assign own_close = own_take && sample_last;
	assign nbr_take = accept && (pmma_pkg::func_t'(func) == pmma_pkg::FUNC_NBR);
	assign commit = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	assign room = own_seen_q < CNT_W'(SAMPLES_PER_ROUND);
	assign own_min_n = (room && sample_value < own_min_q) ? sample_value : own_min_q;
	assign own_max_n = (room && sample_value > own_max_q) ? sample_value : own_max_q;
	assign own_sum_n = room ? own_sum_q + SUM_W'(sample_value) : own_sum_q;
	assign own_seen_n = room ? own_seen_q + 1'b1 : own_seen_q;

	assign mrg_mask = agg_mask_q | rec_mask_q;
	assign mrg_min = (rec_min_q < agg_min_q) ? rec_min_q : agg_min_q;
	assign mrg_max = (rec_max_q > agg_max_q) ? rec_max_q : agg_max_q;
	assign mrg_avg = flag_q ? agg_avg_q : new_avg_q;

	assign div_start = own_close
		|| ((state_q == S_SUM) && ws_stat.done && (ws_count != '0));
	assign div_num = (state_q == S_IDLE) ? NUM_W'(own_sum_n) : ws_total;
	assign div_den = (state_q == S_IDLE) ? DEN_W'(own_seen_n) : ws_count;

	pmma_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quot   (div_quot),
		.stat   (div_stat)
	);

	pmma_wsum #(
		.VAL_W (VALUE_WIDTH),
		.NUM_W (NUM_W)
	) u_wsum (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ws_start_q),
		.mask_a (rec_mask_q),
		.mask_b (agg_mask_q),
		.val_a  (rec_avg_q),
		.val_b  (agg_avg_q),
		.total  (ws_total),
		.count  (ws_count),
		.stat   (ws_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			own_node_q <= '0;
			agg_mask_q <= '0;
			agg_min_q <= '1;
			agg_max_q <= '0;
			agg_avg_q <= '0;
			own_min_q <= '1;
			own_max_q <= '0;
			own_sum_q <= '0;
			own_seen_q <= '0;
			rsp_valid_q <= 1'b0;
			ws_start_q <= 1'b0;
			flag_q <= 1'b0;
		end else begin
			ws_start_q <= nbr_take || ((state_q == S_OWNDIV) && div_stat.done);
			if (cfg_we) begin
				own_node_q <= cfg_data;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (own_take) begin
						if (sample_last) begin
							own_min_q <= '1;
							own_max_q <= '0;
							own_sum_q <= '0;
							own_seen_q <= '0;
							state_q <= S_OWNDIV;
						end else begin
							own_min_q <= own_min_n;
							own_max_q <= own_max_n;
							own_sum_q <= own_sum_n;
							own_seen_q <= own_seen_n;
						end
					end else if (nbr_take) begin
						state_q <= S_SUM;
					end else if (accept
						&& pmma_pkg::func_t'(func) == pmma_pkg::FUNC_CLR) begin
						agg_mask_q <= '0;
						agg_min_q <= '1;
						agg_max_q <= '0;
						agg_avg_q <= '0;
					end
				end
				S_OWNDIV: begin
					if (div_stat.done) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					if (ws_stat.done) begin
						flag_q <= (ws_count == '0);
						state_q <= (ws_count == '0) ? S_DONE : S_DIV;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (commit) begin
						agg_mask_q <= mrg_mask;
						agg_min_q <= mrg_min;
						agg_max_q <= mrg_max;
						agg_avg_q <= mrg_avg;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (own_close) begin
			rec_mask_q <= MB'(1) << own_node_q;
			rec_min_q <= own_min_n;
			rec_max_q <= own_max_n;
		end else if (nbr_take) begin
			rec_mask_q <= neighbour_mask;
			rec_min_q <= neighbour_min;
			rec_max_q <= neighbour_max;
			rec_avg_q <= neighbour_avg;
		end
		if (state_q == S_OWNDIV && div_stat.done) begin
			rec_avg_q <= div_quot[VALUE_WIDTH-1:0];
		end
		if (state_q == S_DIV && div_stat.done) begin
			new_avg_q <= div_quot[VALUE_WIDTH-1:0];
		end
		if (commit) begin
			merged_mask_q <= mrg_mask;
			merged_min_q <= mrg_min;
			merged_max_q <= mrg_max;
			merged_avg_q <= mrg_avg;
			no_part_q <= flag_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign merged_mask = merged_mask_q;
	assign merged_min = merged_min_q;
	assign merged_max = merged_max_q;
	assign merged_avg = merged_avg_q;
	assign no_participants = no_part_q;

	a_ready_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> (!div_stat.busy && !ws_stat.busy))
		else $error("input ready while a serial unit is busy");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_OWNDIV || state_q == S_DIV))
		else $error("divider finished outside a divide state");

	a_ws_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		ws_stat.done |-> (state_q == S_SUM))
		else $error("weighted sum finished outside its state");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised without a finished merge");

	a_flag_keeps_avg: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && flag_q) |=> (agg_avg_q == $past(agg_avg_q)))
		else $error("average changed on a merge without participants");

endmodule

// ----- dv/pooled_min_max_avg_merge_test.sv -----
module pooled_min_max_avg_merge_test;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int ROUND_LEN = pmma_pkg::SAMPLES_PER_ROUND_DEF;
	localparam int PHASES = 8;
	localparam int PER_PHASE = 230;
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES = 700;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [1:0]  fn;
		logic [15:0] sval;
		logic        slast;
		logic [15:0] nmask;
		logic [15:0] nlo;
		logic [15:0] nhi;
		logic [15:0] navg;
	} req_t;

	typedef struct packed {
		logic [15:0] mask;
		logic [15:0] lo;
		logic [15:0] hi;
		logic [15:0] avg;
		logic        nobody;
	} rsp_t;

	typedef struct packed {
		req_t rq;
		logic pinned;
		rsp_t want;
	} row_t;

	localparam rsp_t NO_PIN = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [pmma_pkg::NODE_W-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic rsp_ready = 1'b0;
	req_t drv = '0;
	logic pin_on = 1'b0;
	rsp_t pin_want = '0;

	logic req_ready;
	logic rsp_valid;
	logic [15:0] merged_mask;
	logic [15:0] merged_min;
	logic [15:0] merged_max;
	logic [15:0] merged_avg;
	logic no_participants;

	pooled_min_max_avg_merge DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.func(drv.fn),
		.sample_value(drv.sval),
		.sample_last(drv.slast),
		.neighbour_mask(drv.nmask),
		.neighbour_min(drv.nlo),
		.neighbour_max(drv.nhi),
		.neighbour_avg(drv.navg),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.merged_mask(merged_mask),
		.merged_min(merged_min),
		.merged_max(merged_max),
		.merged_avg(merged_avg),
		.no_participants(no_participants)
	);

	logic [15:0] pool_mask = 16'h0000;
	logic [15:0] pool_min = 16'hFFFF;
	logic [15:0] pool_max = 16'h0000;
	logic [15:0] pool_avg = 16'h0000;
	logic [15:0] round_min = 16'hFFFF;
	logic [15:0] round_max = 16'h0000;
	int unsigned round_sum = 0;
	int unsigned round_cnt = 0;
	logic [3:0] node_cfg = 4'd0;

	rsp_t merged_q[$];
	req_t plan_q[$];
	row_t row_q[$];
	int errors = 0;
	int cycles = 0;
	int holds_asked = 0;
	bit calm = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic rsp_t absorb_record(input logic [15:0] m, input logic [15:0] lo,
			input logic [15:0] hi, input logic [15:0] av);
		rsp_t r;
		int unsigned cin;
		int unsigned ccur;
		int unsigned num;
		cin = $countones(m);
		ccur = $countones(pool_mask);
		if (lo < pool_min) pool_min = lo;
		if (hi > pool_max) pool_max = hi;
		r.nobody = (cin + ccur == 0);
		if (!r.nobody) begin
			num = av * cin + pool_avg * ccur;
			pool_avg = 16'(num / (cin + ccur));
		end
		pool_mask = pool_mask | m;
		r.mask = pool_mask;
		r.lo = pool_min;
		r.hi = pool_max;
		r.avg = pool_avg;
		return r;
	endfunction

	function automatic bit fold_item(input req_t it, output rsp_t res);
		logic [15:0] avg;
		res = '0;
		case (it.fn)
			pmma_pkg::FUNC_OWN: begin
				if (round_cnt < ROUND_LEN) begin
					if (it.sval < round_min) round_min = it.sval;
					if (it.sval > round_max) round_max = it.sval;
					round_sum += it.sval;
					round_cnt++;
				end
				if (!it.slast) return 1'b0;
				avg = (round_cnt != 0) ? 16'(round_sum / round_cnt) : 16'h0000;
				res = absorb_record(16'(1) << node_cfg, round_min, round_max, avg);
				round_min = 16'hFFFF;
				round_max = 16'h0000;
				round_sum = 0;
				round_cnt = 0;
				return 1'b1;
			end
			pmma_pkg::FUNC_NBR: begin
				res = absorb_record(it.nmask, it.nlo, it.nhi, it.navg);
				return 1'b1;
			end
			pmma_pkg::FUNC_CLR: begin
				pool_mask = 16'h0000;
				pool_min = 16'hFFFF;
				pool_max = 16'h0000;
				pool_avg = 16'h0000;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	task automatic cmp_field(input string tag, input logic [15:0] e, input logic [15:0] a);
		if (e !== a) begin
			$display("%0t: %s expected %h, got %h", $time, tag, e, a);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		rsp_t got;
		rsp_t exp;
		bit made;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			if (rsp_valid && rsp_ready) begin
				got = '{merged_mask, merged_min, merged_max, merged_avg, no_participants};
				if (merged_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h", $time, got);
					errors++;
				end else begin
					exp = merged_q.pop_front();
					cmp_field("merged_mask", exp.mask, got.mask);
					cmp_field("merged_min", exp.lo, got.lo);
					cmp_field("merged_max", exp.hi, got.hi);
					cmp_field("merged_avg", exp.avg, got.avg);
					cmp_field("no_participants", 16'(exp.nobody), 16'(got.nobody));
				end
			end
			if (req_valid && req_ready) begin
				made = fold_item(drv, exp);
				if (made) merged_q.push_back(pin_on ? pin_want : exp);
			end
		end
	end

	initial begin
		int gap;
		int holds_done;
		holds_done = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 17);
			if (holds_done != holds_asked) begin
				gap = HOLD_CYCLES;
				holds_done++;
			end
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'(1) << $urandom_range(0, 15);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic req_t noise_req();
		req_t it;
		it.fn = 2'($urandom);
		it.sval = 16'($urandom);
		it.slast = 1'($urandom);
		it.nmask = 16'($urandom);
		it.nlo = 16'($urandom);
		it.nhi = 16'($urandom);
		it.navg = 16'($urandom);
		return it;
	endfunction

	function automatic req_t nbr_req();
		req_t it;
		it = noise_req();
		it.fn = pmma_pkg::FUNC_NBR;
		it.nmask = pick_value();
		it.nlo = pick_value();
		it.nhi = pick_value();
		it.navg = pick_value();
		return it;
	endfunction

	function automatic void plan_episode();
		req_t it;
		int kind;
		int n;
		kind = $urandom_range(0, 99);
		if (kind < 45) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
			for (int k = 0; k < n; k++) begin
				it = noise_req();
				it.fn = pmma_pkg::FUNC_OWN;
				it.sval = pick_value();
				it.slast = (k == n - 1);
				plan_q.push_back(it);
				if ($urandom_range(0, 15) == 0) plan_q.push_back(nbr_req());
				if ($urandom_range(0, 39) == 0) begin
					it = noise_req();
					it.fn = pmma_pkg::FUNC_CLR;
					plan_q.push_back(it);
				end
			end
		end else if (kind < 88) begin
			plan_q.push_back(nbr_req());
		end else if (kind < 94) begin
			it = noise_req();
			it.fn = pmma_pkg::FUNC_CLR;
			plan_q.push_back(it);
		end else begin
			it = noise_req();
			it.fn = FUNC_UNUSED;
			plan_q.push_back(it);
		end
	endfunction

	function automatic req_t mk(input logic [1:0] f, input logic [15:0] v, input logic l,
			input logic [15:0] m, input logic [15:0] lo, input logic [15:0] hi,
			input logic [15:0] av);
		req_t it;
		it = '{f, v, l, m, lo, hi, av};
		return it;
	endfunction

	task automatic offer(input req_t it, input logic pinned, input rsp_t want);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		drv <= it;
		pin_on <= pinned;
		pin_want <= want;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (merged_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_node(input logic [3:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		node_cfg = v;
	endtask

	initial begin
		req_t it;
		row_t rw;
		int sent;
		int waited;
		logic [3:0] node;

		row_q.push_back('{mk(pmma_pkg::FUNC_NBR, 16'h0000, 1'b0,
			16'h0000, 16'hFFFF, 16'h0000, 16'h1234),
			1'b1, '{16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b1}});
		row_q.push_back('{mk(pmma_pkg::FUNC_NBR, 16'h0000, 1'b0,
			16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF),
			1'b1, '{16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0}});
		row_q.push_back('{mk(pmma_pkg::FUNC_NBR, 16'hFFFF, 1'b1,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000),
			1'b1, '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h7FFF, 1'b0}});
		row_q.push_back('{mk(pmma_pkg::FUNC_CLR, 16'hFFFF, 1'b1,
			16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF),
			1'b0, NO_PIN});
		row_q.push_back('{mk(FUNC_UNUSED, 16'h0000, 1'b1,
			16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001),
			1'b0, NO_PIN});
		row_q.push_back('{mk(pmma_pkg::FUNC_OWN, 16'h0000, 1'b1,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
			1'b1, '{16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b0}});
		row_q.push_back('{mk(pmma_pkg::FUNC_OWN, 16'hFFFF, 1'b1,
			16'h0000, 16'h0000, 16'h0000, 16'h0000),
			1'b1, '{16'h0001, 16'h0000, 16'hFFFF, 16'h7FFF, 1'b0}});
		row_q.push_back('{mk(pmma_pkg::FUNC_CLR, 16'h0000, 1'b0,
			16'h0000, 16'h0000, 16'h0000, 16'h0000),
			1'b0, NO_PIN});
		for (int k = 0; k < 10; k++) begin
			row_q.push_back('{mk(pmma_pkg::FUNC_OWN, 16'(16'h1000 * k + 16'h000F), (k == 9),
				16'h5A5A, 16'hA5A5, 16'h5A5A, 16'hA5A5), 1'b0, NO_PIN});
		end
		row_q.push_back('{mk(pmma_pkg::FUNC_NBR, 16'h0000, 1'b0,
			16'h0000, 16'h0005, 16'h0009, 16'hFFFF),
			1'b0, NO_PIN});
		row_q.push_back('{mk(pmma_pkg::FUNC_NBR, 16'h0000, 1'b0,
			16'h8000, 16'h0001, 16'hFFFE, 16'h0000),
			1'b0, NO_PIN});
		row_q.push_back('{mk(FUNC_UNUSED, 16'hFFFF, 1'b0,
			16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF),
			1'b0, NO_PIN});
		row_q.push_back('{mk(pmma_pkg::FUNC_OWN, 16'h4321, 1'b0,
			16'h0000, 16'h0000, 16'h0000, 16'h0000),
			1'b0, NO_PIN});
		row_q.push_back('{mk(pmma_pkg::FUNC_CLR, 16'h0000, 1'b0,
			16'h0000, 16'h0000, 16'h0000, 16'h0000),
			1'b0, NO_PIN});
		row_q.push_back('{mk(pmma_pkg::FUNC_OWN, 16'hFFFF, 1'b1,
			16'h0000, 16'h0000, 16'h0000, 16'h0000),
			1'b0, NO_PIN});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (row_q[i]) begin
			rw = row_q[i];
			offer(rw.rq, rw.pinned, rw.want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: node = 4'd15;
				1: node = 4'd0;
				2: node = 4'd7;
				default: node = 4'($urandom_range(0, 15));
			endcase
			set_node(node);
			calm = (ph == 3 || ph == 6);
			if (ph == 1) holds_asked++;
			sent = 0;
			while (sent < PER_PHASE) begin
				if (plan_q.size() == 0) plan_episode();
				it = plan_q.pop_front();
				offer(it, 1'b0, NO_PIN);
				if (it.fn != FUNC_UNUSED) sent++;
			end
		end

		req_valid <= 1'b0;
		waited = 0;
		while (merged_q.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (merged_q.size() != 0) begin
			$display("%0t: %0d results expected, got none", $time, merged_q.size());
			errors++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/pmma_pkg.sv
rtl/pmma_div.sv
rtl/pmma_wsum.sv
rtl/pooled_min_max_avg_merge.sv
dv/pooled_min_max_avg_merge_test.sv
